>>> rtl/trb_pkg.sv
// shared types and constants for the timestamped receive ring buffer
package trb_pkg;

   localparam int CMD_W = 2;
   localparam int CHAN_W = 2;
   localparam int CHAR_W = 16;
   localparam int TIME_W = 32;
   localparam int ENTRY_W = CHAR_W + TIME_W;

   localparam logic [CMD_W-1:0] CMD_RECEIVE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT = 2'd2;

   localparam logic [CHAR_W-1:0] EMPTY_READ = 16'hEEEE;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [CHAN_W-1:0] channel;
      logic [CHAR_W-1:0] rx_char;
      logic [TIME_W-1:0] timer_now;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] read_data;
      logic [TIME_W-1:0] read_time_diff;
      logic data_available;
      logic dropped;
      logic [TIME_W-1:0] overflow_count;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic respond;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RESP = 2'b10
   } state_type;

endpackage

>>> rtl/timestamped_rx_ring_buffer_top.sv
// top level of the timestamped multi-channel receive ring buffer
//
// a request (req_data) transfers at a rising edge where start is high and
// busy is low; cmd selects receive, read oldest entry or init channel
// each request gives exactly one response on rsp_data, marked by rsp_valid
// for one cycle, in the cycle right after the request transfer
// busy is high during that response cycle, so no new request transfers
// until it is over; the entry ram is read and written in the request cycle
// and its registered read data feeds the response
// the receiver cannot stall; rsp_valid is never held off
// csr_we with csr_wdata sets timer_counts_down at any edge, used while idle
// reset (synchronous, active high) empties every channel, zeroes the timer
// samples, latched differences and drop counters, and sets
// timer_counts_down to 1; the entry ram needs no clearing and the block
// takes requests in the first cycle after reset
module timestamped_rx_ring_buffer_top #(
   parameter int DEPTH = 64,
   parameter int CHANNELS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  trb_pkg::req_type req_data,
   output logic             rsp_valid,
   output trb_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   trb_pkg::ctl_type ctl;

   trb_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .ctl(ctl)
   );

   trb_datapath #(
      .DEPTH(DEPTH),
      .CHANNELS(CHANNELS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .req(req_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .rsp(rsp_data)
   );

   assign rsp_valid = ctl.respond;

endmodule

>>> rtl/trb_ram.sv
// generic single-write, single-read ram with registered read data
module trb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/trb_ctrl.sv
// command sequencer: accepts one request, then issues its response
module trb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output trb_pkg::ctl_type ctl
);

   trb_pkg::state_type state_ff;
   trb_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trb_pkg::ST_IDLE: begin
            if (start) begin
               state_in = trb_pkg::ST_RESP;
            end
         end
         trb_pkg::ST_RESP: begin
            state_in = trb_pkg::ST_IDLE;
         end
         default: begin
            state_in = trb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != trb_pkg::ST_IDLE);
   assign ctl.accept = start && (state_ff == trb_pkg::ST_IDLE);
   assign ctl.respond = (state_ff == trb_pkg::ST_RESP);

endmodule

>>> rtl/trb_datapath.sv
// per-channel pointers, counters and timestamps plus the shared entry ram
module trb_datapath #(
   parameter int DEPTH = 64,
   parameter int CHANNELS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  trb_pkg::ctl_type ctl,
   input  trb_pkg::req_type req,
   input  logic             csr_we,
   input  logic             csr_wdata,
   output trb_pkg::rsp_type rsp
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RAM_DEPTH = CHANNELS << PTR_W;
   localparam int RAM_AW = $clog2(RAM_DEPTH);
   localparam int TW = trb_pkg::TIME_W;
   localparam int CW = trb_pkg::CHAR_W;

   logic [PTR_W-1:0]  wptr_ff [CHANNELS];
   logic [PTR_W-1:0]  wptr_in [CHANNELS];
   logic [PTR_W-1:0]  rptr_ff [CHANNELS];
   logic [PTR_W-1:0]  rptr_in [CHANNELS];
   logic [FILL_W-1:0] fill_ff [CHANNELS];
   logic [FILL_W-1:0] fill_in [CHANNELS];
   logic [TW-1:0]     last_timer_ff [CHANNELS];
   logic [TW-1:0]     last_timer_in [CHANNELS];
   logic [TW-1:0]     last_delta_ff [CHANNELS];
   logic [TW-1:0]     last_delta_in [CHANNELS];
   logic [TW-1:0]     drop_cnt_ff [CHANNELS];
   logic [TW-1:0]     drop_cnt_in [CHANNELS];

   logic              count_down_ff;
   logic              from_ram_ff;
   logic              from_ram_in;
   logic [CH_W-1:0]   ch_ff;
   logic [CW-1:0]     rdata_ff;
   logic [CW-1:0]     rdata_in;
   logic [TW-1:0]     diff_ff;
   logic [TW-1:0]     diff_in;
   logic              avail_ff;
   logic              avail_in;
   logic              drop_ff;
   logic              drop_in;
   logic [TW-1:0]     ovf_ff;
   logic [TW-1:0]     ovf_in;

   logic              ch_valid;
   logic [CH_W-1:0]   ch;
   logic [TW-1:0]     delta;
   logic              full;
   logic              empty;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr;
   logic [RAM_AW-1:0] ram_raddr;
   logic [trb_pkg::ENTRY_W-1:0] ram_wdata;
   logic [trb_pkg::ENTRY_W-1:0] ram_rdata;

   assign ch_valid = (32'(req.channel) < CHANNELS);
   assign ch = CH_W'(req.channel);
   assign full = (fill_ff[ch] == FILL_W'(DEPTH));
   assign empty = (fill_ff[ch] == '0);
   assign delta = count_down_ff ? (last_timer_ff[ch] - req.timer_now)
                                : (req.timer_now - last_timer_ff[ch]);
   assign ram_waddr = RAM_AW'({ch, wptr_ff[ch]});
   assign ram_raddr = RAM_AW'({ch, rptr_ff[ch]});
   assign ram_wdata = {req.rx_char, delta};

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      last_timer_in = last_timer_ff;
      last_delta_in = last_delta_ff;
      drop_cnt_in = drop_cnt_ff;
      ram_we = 1'b0;
      from_ram_in = 1'b0;
      rdata_in = '0;
      drop_in = 1'b0;

      if (ctl.accept && ch_valid) begin
         case (req.cmd)
            trb_pkg::CMD_RECEIVE: begin
               if (full) begin
                  drop_cnt_in[ch] = drop_cnt_ff[ch] + 1'b1;
                  drop_in = 1'b1;
               end else begin
                  ram_we = 1'b1;
                  last_timer_in[ch] = req.timer_now;
                  wptr_in[ch] = (wptr_ff[ch] == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff[ch] + 1'b1;
                  fill_in[ch] = fill_ff[ch] + 1'b1;
               end
            end
            trb_pkg::CMD_READ: begin
               if (empty) begin
                  rdata_in = trb_pkg::EMPTY_READ;
               end else begin
                  from_ram_in = 1'b1;
                  rptr_in[ch] = (rptr_ff[ch] == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff[ch] + 1'b1;
                  fill_in[ch] = fill_ff[ch] - 1'b1;
               end
            end
            trb_pkg::CMD_INIT: begin
               wptr_in[ch] = '0;
               rptr_in[ch] = '0;
               fill_in[ch] = '0;
               last_timer_in[ch] = req.timer_now;
            end
            default: begin
            end
         endcase
      end

      if (ctl.respond && from_ram_ff) begin
         last_delta_in[ch_ff] = ram_rdata[TW-1:0];
      end

      if (ch_valid) begin
         diff_in = last_delta_ff[ch];
         avail_in = (fill_in[ch] != '0);
         ovf_in = drop_cnt_in[ch];
      end else begin
         diff_in = '0;
         avail_in = 1'b0;
         ovf_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            wptr_ff[i] <= '0;
            rptr_ff[i] <= '0;
            fill_ff[i] <= '0;
            last_timer_ff[i] <= '0;
            last_delta_ff[i] <= '0;
            drop_cnt_ff[i] <= '0;
         end
         count_down_ff <= 1'b1;
         from_ram_ff <= 1'b0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
         last_timer_ff <= last_timer_in;
         last_delta_ff <= last_delta_in;
         drop_cnt_ff <= drop_cnt_in;
         if (csr_we) begin
            count_down_ff <= csr_wdata;
         end
         if (ctl.accept) begin
            from_ram_ff <= from_ram_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         ch_ff <= ch;
         rdata_ff <= rdata_in;
         diff_ff <= diff_in;
         avail_ff <= avail_in;
         drop_ff <= drop_in;
         ovf_ff <= ovf_in;
      end
   end

   trb_ram #(
      .WIDTH(trb_pkg::ENTRY_W),
      .DEPTH(RAM_DEPTH)
   ) u_entry_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en(ctl.accept),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rsp.read_data = from_ram_ff ? ram_rdata[trb_pkg::ENTRY_W-1:TW] : rdata_ff;
   assign rsp.read_time_diff = from_ram_ff ? ram_rdata[TW-1:0] : diff_ff;
   assign rsp.data_available = avail_ff;
   assign rsp.dropped = drop_ff;
   assign rsp.overflow_count = ovf_ff;

endmodule

>>> test/tb_timestamped_rx_ring_buffer_top.sv
// self-checking testbench for the timestamped multi-channel receive ring buffer
module tb_timestamped_rx_ring_buffer_top;
   import trb_pkg::*;

   localparam int DEPTH = 64;
   localparam int CHANNELS = 4;
   localparam int STALL_LIMIT = 2000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we;
   logic csr_wdata;

   // ring model
   logic [CHAR_W-1:0] ring_chars [CHANNELS][DEPTH];
   logic [TIME_W-1:0] ring_deltas [CHANNELS][DEPTH];
   int unsigned ring_wr [CHANNELS];
   int unsigned ring_rd [CHANNELS];
   int unsigned ring_fill [CHANNELS];
   logic [TIME_W-1:0] ring_last_time [CHANNELS];
   logic [TIME_W-1:0] ring_last_delta [CHANNELS];
   logic [TIME_W-1:0] ring_drops [CHANNELS];
   logic timer_down;

   rsp_type awaited_rsp [$];
   int mismatch_count = 0;
   int stall_cycles = 0;
   bit idle_on;
   logic [TIME_W-1:0] tick;

   timestamped_rx_ring_buffer_top #(
      .DEPTH(DEPTH),
      .CHANNELS(CHANNELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type ring_response(input req_type rq);
      rsp_type rs;
      int unsigned ch;
      int unsigned slot;
      rs = '0;
      ch = 32'(rq.channel);
      if (ch >= CHANNELS) return rs;
      case (rq.cmd)
         CMD_RECEIVE: begin
            if (ring_fill[ch] >= DEPTH) begin
               ring_drops[ch] = ring_drops[ch] + 1;
               rs.dropped = 1'b1;
            end else begin
               slot = ring_wr[ch];
               ring_deltas[ch][slot] = timer_down ? ring_last_time[ch] - rq.timer_now
                                                  : rq.timer_now - ring_last_time[ch];
               ring_chars[ch][slot] = rq.rx_char;
               ring_last_time[ch] = rq.timer_now;
               ring_wr[ch] = (slot + 1) % DEPTH;
               ring_fill[ch]++;
            end
         end
         CMD_READ: begin
            if (ring_fill[ch] == 0) begin
               rs.read_data = EMPTY_READ;
            end else begin
               slot = ring_rd[ch];
               ring_last_delta[ch] = ring_deltas[ch][slot];
               rs.read_data = ring_chars[ch][slot];
               ring_rd[ch] = (slot + 1) % DEPTH;
               ring_fill[ch]--;
            end
         end
         CMD_INIT: begin
            ring_wr[ch] = 0;
            ring_rd[ch] = 0;
            ring_fill[ch] = 0;
            ring_last_time[ch] = rq.timer_now;
         end
         default: ;
      endcase
      rs.read_time_diff = ring_last_delta[ch];
      rs.data_available = (ring_fill[ch] != 0);
      rs.overflow_count = ring_drops[ch];
      return rs;
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            ring_wr[c] = 0;
            ring_rd[c] = 0;
            ring_fill[c] = 0;
            ring_last_time[c] = '0;
            ring_last_delta[c] = '0;
            ring_drops[c] = '0;
         end
         timer_down = 1'b1;
         awaited_rsp.delete();
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response with none expected, actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_data.read_data);
                  mismatch_count++;
               end
               if (rsp_data.read_time_diff !== want.read_time_diff) begin
                  $display("%0t: read_time_diff expected %h actual %h",
                           $time, want.read_time_diff, rsp_data.read_time_diff);
                  mismatch_count++;
               end
               if (rsp_data.data_available !== want.data_available) begin
                  $display("%0t: data_available expected %b actual %b",
                           $time, want.data_available, rsp_data.data_available);
                  mismatch_count++;
               end
               if (rsp_data.dropped !== want.dropped) begin
                  $display("%0t: dropped expected %b actual %b",
                           $time, want.dropped, rsp_data.dropped);
                  mismatch_count++;
               end
               if (rsp_data.overflow_count !== want.overflow_count) begin
                  $display("%0t: overflow_count expected %h actual %h",
                           $time, want.overflow_count, rsp_data.overflow_count);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) awaited_rsp.push_back(ring_response(req_data));
         if (csr_we) timer_down = csr_wdata;
         if (rsp_valid || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // one request transfer, start left high on return
   task automatic issue(input logic [CMD_W-1:0] op, input logic [CHAN_W-1:0] ch,
                        input logic [CHAR_W-1:0] chr, input logic [TIME_W-1:0] now);
      if (idle_on && $urandom_range(99) < 7) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= '{op, ch, chr, now};
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_count_down(input logic down);
      drain_responses();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= down;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_empty_read();
      issue(CMD_READ, 2'd0, 16'hFFFF, 32'hFFFF_FFFF);
      issue(CMD_READ, 2'd3, 16'h0000, 32'h0000_0000);
   endtask

   task automatic test_receive_read();
      issue(CMD_RECEIVE, 2'd0, 16'hFFFF, 32'h0000_0000);
      issue(CMD_RECEIVE, 2'd0, 16'h0000, 32'hFFFF_FFFF);
      issue(CMD_RECEIVE, 2'd0, 16'hA5A5, 32'h0000_0000);
      repeat (3) issue(CMD_READ, 2'd0, 16'h0000, 32'h0000_0000);
      // empty read keeps the latched difference
      issue(CMD_READ, 2'd0, 16'h0000, 32'h0000_0000);
   endtask

   task automatic test_init_channel();
      issue(CMD_RECEIVE, 2'd1, 16'h1234, 32'd100);
      issue(CMD_RECEIVE, 2'd1, 16'h5678, 32'd40);
      issue(CMD_READ, 2'd1, 16'h0000, 32'h0000_0000);
      issue(CMD_INIT, 2'd1, 16'hFFFF, 32'hFFFF_FFFF);
      issue(CMD_READ, 2'd1, 16'h0000, 32'h0000_0000);
      issue(CMD_RECEIVE, 2'd1, 16'h8001, 32'h0000_0000);
      issue(CMD_READ, 2'd1, 16'h0000, 32'h0000_0000);
   endtask

   task automatic test_unused_cmd();
      issue(CMD_RECEIVE, 2'd3, 16'h00FF, 32'h8000_0000);
      issue(CMD_UNUSED, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      issue(CMD_UNUSED, 2'd2, CHAR_W'($urandom), $urandom);
      issue(CMD_READ, 2'd3, 16'h0000, 32'h0000_0000);
   endtask

   task automatic test_count_up();
      set_count_down(1'b0);
      issue(CMD_INIT, 2'd2, 16'h0000, 32'd10);
      issue(CMD_RECEIVE, 2'd2, 16'h7FFF, 32'd25);
      issue(CMD_RECEIVE, 2'd2, 16'h8000, 32'd5);
      repeat (2) issue(CMD_READ, 2'd2, 16'h0000, 32'h0000_0000);
   endtask

   task automatic test_full_ring();
      logic [TIME_W-1:0] now;
      now = $urandom;
      issue(CMD_INIT, 2'd2, 16'h0000, now);
      for (int i = 0; i < DEPTH; i++) begin
         now = now + $urandom_range(1, 500);
         issue(CMD_RECEIVE, 2'd2, CHAR_W'($urandom), now);
      end
      repeat (3) issue(CMD_RECEIVE, 2'd2, CHAR_W'($urandom), $urandom);
      issue(CMD_READ, 2'd2, 16'h0000, 32'h0000_0000);
      issue(CMD_RECEIVE, 2'd2, CHAR_W'($urandom), now + 7);
      issue(CMD_RECEIVE, 2'd2, CHAR_W'($urandom), $urandom);
      repeat (DEPTH + 1) issue(CMD_READ, 2'd2, 16'h0000, 32'h0000_0000);
   endtask

   task automatic run_traffic(input logic down, input int recv_pct, input int chan_hi,
                              input int count);
      int pick;
      logic [CMD_W-1:0] op;
      logic [TIME_W-1:0] now;
      set_count_down(down);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < recv_pct) op = CMD_RECEIVE;
         else if (pick < 96) op = CMD_READ;
         else if (pick < 99) op = CMD_INIT;
         else op = CMD_UNUSED;
         if ($urandom_range(9) == 0) tick = $urandom;
         else if (down) tick = tick - $urandom_range(1, 3000);
         else tick = tick + $urandom_range(1, 3000);
         now = ($urandom_range(19) == 0) ? $urandom : tick;
         issue(op, CHAN_W'($urandom_range(chan_hi)), CHAR_W'($urandom), now);
      end
   endtask

   task automatic test_random_traffic();
      run_traffic(1'b1, 55, 3, 250);
      run_traffic(1'b0, 75, 1, 250);
      idle_on = 1'b0;
      run_traffic(1'b0, 50, 3, 250);
      idle_on = 1'b1;
      run_traffic(1'b1, 30, 3, 250);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      idle_on = 1'b1;
      tick = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_read();
      test_receive_read();
      test_init_channel();
      test_unused_cmd();
      test_count_up();
      set_count_down(1'b1);
      test_full_ring();
      test_random_traffic();
      drain_responses();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/trb_pkg.sv
rtl/trb_ram.sv
rtl/trb_ctrl.sv
rtl/trb_datapath.sv
rtl/timestamped_rx_ring_buffer_top.sv
test/tb_timestamped_rx_ring_buffer_top.sv
